@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file y0sd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/y0sd_pkg.sv @@
package y0sd_pkg;

	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int LANES_DEF = 8;
	localparam logic [31:0] YAZ_MAGIC = 32'h5961_7A30;
	localparam logic [8:0] LONG_BIAS = 9'h012;
	localparam logic [8:0] SHORT_BIAS = 9'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic starts_file;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [7:0] out_byte4;
		logic [7:0] out_byte5;
		logic [7:0] out_byte6;
		logic [7:0] out_byte7;
		logic [3:0] byte_count;
		logic run_end;
		logic stream_end;
		logic truncated;
	} out_word_t;

endpackage

@@ design/yaz0_stream_decompressor.sv @@
// Channel  Handshake                Word
// in       in_valid / in_ready      y0sd_pkg::in_word_t (data_byte, starts_file)
// out      out_valid / out_ready    y0sd_pkg::out_word_t (eight bytes, count, flags)
// cfg      cfg_valid / cfg_ready    cfg_data, the 24-bit raw length
// Header, group, code, literal and raw bytes are each taken in ST_IDLE.
// A back-reference copies each byte through ST_RD, the history read, then ST_WR, the write.
// A mismatched magic word is sent on as output bytes from ST_MAGIC.
// Every input byte, magic byte and copied byte waits while the output register holds an
// untaken word.
// Reset clears all control state; the history memory is not cleared.
module yaz0_stream_decompressor #(
	parameter int WINDOW_DEPTH = y0sd_pkg::WINDOW_DEPTH_DEF,
	parameter int LANES = y0sd_pkg::LANES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input y0sd_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_ready,
	output y0sd_pkg::out_word_t out_word,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [23:0] cfg_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CHUNK = (LANES < 8) ? LANES : 8;
	localparam int CW = $clog2(CHUNK);

	typedef enum logic [1:0] {M_HEADER, M_DATA, M_RAW, M_DONE} mode_t;
	typedef enum logic [2:0] {ST_IDLE, ST_MAGIC, ST_RD, ST_WR} state_t;

	logic [7:0] ring [WINDOW_DEPTH];
	logic [7:0] ring_rd_q;

	state_t state_q;
	mode_t mode_q;
	logic [23:0] raw_q;
	logic [AW-1:0] wp_q;
	logic [4:0] hidx_q;
	logic [31:0] magic_q;
	logic [31:0] total_q;
	logic [31:0] produced_q;
	logic [7:0] group_q;
	logic [3:0] gleft_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic [1:0] phase_q;
	logic [8:0] len_q;
	logic [1:0] k_q;
	logic [7:0] cbuf_q [CHUNK];
	logic [CW-1:0] ccnt_q;
	logic out_v_q;
	y0sd_pkg::out_word_t out_q;

	logic slot_free, acc, restart;
	mode_t e_mode;
	logic [4:0] e_hidx;
	logic [31:0] e_magic, e_total, magic_n, total_n;
	logic [3:0] e_gleft;
	logic [1:0] e_phase;
	logic [7:0] b;
	logic emit_en, emit_last, emit_fin, emit_cut;
	logic [7:0] emit_v;
	logic ram_we;
	logic [AW-1:0] raddr;
	logic [12:0] back_dist;
	logic [32:0] prod_inc;
	logic [7:0] lane_n [8];

	assign slot_free = !out_v_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && slot_free;
	assign acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign out_word = out_q;
	assign b = in_word.data_byte;
	assign restart = in_word.starts_file;
	assign e_mode = restart ? M_HEADER : mode_q;
	assign e_hidx = restart ? 5'd0 : hidx_q;
	assign e_magic = restart ? 32'd0 : magic_q;
	assign e_total = restart ? 32'd0 : total_q;
	assign e_gleft = restart ? 4'd0 : gleft_q;
	assign e_phase = restart ? 2'd0 : phase_q;
	assign magic_n = (e_hidx < 5'd4) ? {e_magic[23:0], b} : e_magic;
	assign total_n = (e_hidx >= 5'd4 && e_hidx < 5'd8) ? {e_total[23:0], b} : e_total;
	assign prod_inc = {1'b0, produced_q} + 33'd1;
	assign back_dist = {1'b0, first_q[3:0], second_q} + 13'd1;
	assign raddr = wp_q - AW'(back_dist);

	always_comb begin
		emit_en = 1'b0;
		emit_v = b;
		emit_last = 1'b1;
		emit_fin = 1'b0;
		emit_cut = 1'b0;
		ram_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && e_mode == M_RAW && produced_q < {8'd0, raw_q}) begin
					emit_en = 1'b1;
					emit_fin = prod_inc >= {9'd0, raw_q};
				end else if (acc && e_mode == M_DATA && e_gleft != 4'd0 && e_phase == 2'd0
						&& group_q[7]) begin
					emit_en = 1'b1;
					ram_we = 1'b1;
					emit_fin = prod_inc >= {1'b0, total_q};
				end
			end
			ST_MAGIC: begin
				emit_en = slot_free;
				emit_v = magic_q[31 - 8 * k_q -: 8];
				emit_fin = prod_inc >= {9'd0, raw_q};
				emit_last = (k_q == 2'd3) || emit_fin;
			end
			ST_WR: begin
				emit_en = slot_free;
				ram_we = slot_free;
				emit_v = ring_rd_q;
				emit_fin = prod_inc >= {1'b0, total_q};
				emit_last = (len_q == 9'd1) || emit_fin;
				emit_cut = emit_fin && (len_q > 9'd1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (i >= CHUNK) begin
				lane_n[i] = 8'd0;
			end else if (CW'(i) < ccnt_q) begin
				lane_n[i] = cbuf_q[i];
			end else if (CW'(i) == ccnt_q) begin
				lane_n[i] = emit_v;
			end else begin
				lane_n[i] = 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ring[wp_q] <= emit_v;
		end
		if (state_q == ST_RD) begin
			ring_rd_q <= ring[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= M_HEADER;
			raw_q <= '0;
			wp_q <= '0;
			hidx_q <= '0;
			magic_q <= '0;
			total_q <= '0;
			produced_q <= '0;
			group_q <= '0;
			gleft_q <= '0;
			first_q <= '0;
			second_q <= '0;
			phase_q <= '0;
			len_q <= '0;
			k_q <= '0;
			ccnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				raw_q <= cfg_data;
			end
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			if (emit_en) begin
				produced_q <= produced_q + 32'd1;
				cbuf_q[ccnt_q] <= emit_v;
				if (emit_last || ccnt_q == CW'(CHUNK - 1)) begin
					out_v_q <= 1'b1;
					ccnt_q <= '0;
					out_q.out_byte0 <= lane_n[0];
					out_q.out_byte1 <= lane_n[1];
					out_q.out_byte2 <= lane_n[2];
					out_q.out_byte3 <= lane_n[3];
					out_q.out_byte4 <= lane_n[4];
					out_q.out_byte5 <= lane_n[5];
					out_q.out_byte6 <= lane_n[6];
					out_q.out_byte7 <= lane_n[7];
					out_q.byte_count <= 4'(ccnt_q) + 4'd1;
					out_q.run_end <= emit_last;
					out_q.stream_end <= emit_last && emit_fin;
					out_q.truncated <= emit_last && emit_cut;
				end else begin
					ccnt_q <= ccnt_q + CW'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (restart) begin
							wp_q <= '0;
							produced_q <= '0;
							group_q <= '0;
							gleft_q <= '0;
							first_q <= '0;
							second_q <= '0;
							phase_q <= '0;
						end
						unique case (e_mode)
							M_HEADER: begin
								magic_q <= magic_n;
								total_q <= total_n;
								hidx_q <= (e_hidx < 5'd16) ? e_hidx + 5'd1 : e_hidx;
								mode_q <= M_HEADER;
								if (e_hidx == 5'd3 && magic_n != y0sd_pkg::YAZ_MAGIC) begin
									if (raw_q == 24'd0) begin
										mode_q <= M_DONE;
									end else begin
										mode_q <= M_RAW;
										k_q <= '0;
										state_q <= ST_MAGIC;
									end
								end else if (e_hidx >= 5'd15) begin
									mode_q <= (total_n == 32'd0) ? M_DONE : M_DATA;
								end
							end
							M_RAW: begin
								if (!emit_en || emit_fin) begin
									mode_q <= M_DONE;
								end
							end
							M_DATA: begin
								if (gleft_q == 4'd0) begin
									group_q <= b;
									gleft_q <= 4'd8;
								end else if (phase_q == 2'd0) begin
									if (group_q[7]) begin
										wp_q <= wp_q + AW'(1);
										group_q <= {group_q[6:0], 1'b0};
										gleft_q <= gleft_q - 4'd1;
										if (emit_fin) begin
											mode_q <= M_DONE;
										end
									end else begin
										first_q <= b;
										phase_q <= 2'd1;
									end
								end else if (phase_q == 2'd1) begin
									second_q <= b;
									if (first_q[7:4] != 4'd0) begin
										phase_q <= 2'd0;
										len_q <= {5'd0, first_q[7:4]} + y0sd_pkg::SHORT_BIAS;
										group_q <= {group_q[6:0], 1'b0};
										gleft_q <= gleft_q - 4'd1;
										state_q <= ST_RD;
									end else begin
										phase_q <= 2'd2;
									end
								end else begin
									phase_q <= 2'd0;
									len_q <= {1'b0, b} + y0sd_pkg::LONG_BIAS;
									group_q <= {group_q[6:0], 1'b0};
									gleft_q <= gleft_q - 4'd1;
									state_q <= ST_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MAGIC: begin
					if (slot_free) begin
						k_q <= k_q + 2'd1;
						if (emit_last) begin
							mode_q <= emit_fin ? M_DONE : M_RAW;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (slot_free) begin
						wp_q <= wp_q + AW'(1);
						len_q <= len_q - 9'd1;
						if (emit_fin) begin
							mode_q <= M_DONE;
						end
						state_q <= emit_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/y0sd_checker.sv @@
`include "assert_macros.svh"

module y0sd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input y0sd_pkg::out_word_t out_word
);

	logic held, count_ok, end_flagged, end_ok;

	assign held = out_valid && !out_ready;
	assign count_ok = out_word.byte_count != 4'd0 && out_word.byte_count <= 4'd8;
	assign end_flagged = out_valid && (out_word.stream_end || out_word.truncated);
	assign end_ok = out_word.run_end && (out_word.stream_end || !out_word.truncated);

	`ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_word), "Word moved while held.")
	`ASSERT_NOW(a_count_range, out_valid, count_ok, "Byte count out of range.")
	`ASSERT_NOW(a_end_order, end_flagged, end_ok, "End flags inconsistent.")
	`ASSERT_NOW(a_no_accept_blocked, in_ready, !held, "Input taken while output stalled.")

endmodule

bind yaz0_stream_decompressor y0sd_checker u_y0sd_checker (.*);
